// ===== rtl/lightweight_block_cipher_encrypt_defines.svh =====
// assertion macros shared by the rtl
`ifndef LIGHTWEIGHT_BLOCK_CIPHER_ENCRYPT_DEFINES_SVH
`define LIGHTWEIGHT_BLOCK_CIPHER_ENCRYPT_DEFINES_SVH

// same-cycle implication
`define LBCE_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LBCE_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lbce_pkg.sv =====
package lbce_pkg;

  localparam int BLOCK_W    = 64;
  localparam int KEY_W      = 80;
  localparam int KEY_HIGH_W = 16;
  localparam int RC_W       = 5;
  localparam int ROUNDS_DEF = 31;
  localparam int REG_IDX_W  = 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } reg_idx_t;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_W-1:0]   key_t;

  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      4'hF: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic block_t sub_layer(input block_t s);
    block_t r;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      r[4*n +: 4] = sbox(s[4*n +: 4]);
    end
    return r;
  endfunction

  // bit i moves to 16*(i mod 4) + i/4, bit 63 stays
  function automatic block_t perm_layer(input block_t s);
    block_t r;
    r[BLOCK_W-1] = s[BLOCK_W-1];
    for (int i = 0; i < BLOCK_W - 1; i++) begin
      r[16 * (i & 3) + (i >> 2)] = s[i];
    end
    return r;
  endfunction

  function automatic block_t round_key(input key_t k);
    return k[KEY_W-1 -: BLOCK_W];
  endfunction

  function automatic key_t key_update(input key_t k, input logic [RC_W-1:0] rc);
    key_t r;
    r = {k[18:0], k[KEY_W-1:19]};
    r[KEY_W-1 -: 4] = sbox(r[KEY_W-1 -: 4]);
    r[19:15] = r[19:15] ^ rc;
    return r;
  endfunction

endpackage

// ===== rtl/lbce_round.sv =====
`include "lightweight_block_cipher_encrypt_defines.svh"

module lbce_round #(
  parameter logic [lbce_pkg::RC_W-1:0] RC = lbce_pkg::RC_W'(1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      valid_in,
  input  logic [lbce_pkg::BLOCK_W-1:0] state_in,
  input  logic [lbce_pkg::KEY_W-1:0]   key_in,
  output logic                      valid,
  output logic [lbce_pkg::BLOCK_W-1:0] state,
  output logic [lbce_pkg::KEY_W-1:0]   key
);
  import lbce_pkg::*;

  block_t state_next;
  key_t   key_next;

  always_comb begin
    state_next = perm_layer(sub_layer(state_in ^ round_key(key_in)));
    key_next   = key_update(key_in, RC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    state <= state_next;
    key   <= key_next;
  end

  `LBCE_ASSERT_IMP(a_valid_src, clk, rst, valid, $past(valid_in), "round valid without request")
  `LBCE_ASSERT_NXT(a_valid_fwd, clk, rst, valid_in, valid, "round dropped a request")
  `LBCE_ASSERT_IMP(a_key_rot, clk, rst, valid, key[14:0] == $past(key_in[33:19]),
                   "key rotation mismatch")

endmodule

// ===== rtl/lightweight_block_cipher_encrypt.sv =====
// PRESENT-80 encryption, one round per pipeline stage. A plaintext block is
// taken at every clock edge where start is high and busy is low; busy is high
// only while rst is asserted, so a new block can enter every cycle. The
// ciphertext appears on ciphertext with done high for one cycle, after the
// ROUNDS round stages and the whitening output register, in request order.
// The receiver cannot stall, so there is no back-pressure. The key registers
// are written through wr_en/wr_index/wr_data (index 0: key bits 63..0,
// index 1: key bits 79..64 from wr_data[15:0]) and must only change while no
// block is in flight.
`include "lightweight_block_cipher_encrypt_defines.svh"

module lightweight_block_cipher_encrypt #(
  parameter int ROUNDS = lbce_pkg::ROUNDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lbce_pkg::BLOCK_W-1:0]  plaintext,
  output logic                          done,
  output logic [lbce_pkg::BLOCK_W-1:0]  ciphertext,
  input  logic                          wr_en,
  input  logic [lbce_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [lbce_pkg::BLOCK_W-1:0]  wr_data
);
  import lbce_pkg::*;

  logic [BLOCK_W-1:0]    key_low;
  logic [KEY_HIGH_W-1:0] key_high;
  logic                  accept;

  logic   pipe_valid [ROUNDS+1];
  block_t pipe_state [ROUNDS+1];
  key_t   pipe_key   [ROUNDS+1];

  assign busy   = rst;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_KEY_LOW:  key_low  <= wr_data;
        REG_KEY_HIGH: key_high <= wr_data[KEY_HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  assign pipe_valid[0] = accept;
  assign pipe_state[0] = plaintext;
  assign pipe_key[0]   = {key_high, key_low};

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    lbce_round #(
      .RC(RC_W'(i + 1))
    ) u_round (
      .clk      (clk),
      .rst      (rst),
      .valid_in (pipe_valid[i]),
      .state_in (pipe_state[i]),
      .key_in   (pipe_key[i]),
      .valid    (pipe_valid[i+1]),
      .state    (pipe_state[i+1]),
      .key      (pipe_key[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pipe_valid[ROUNDS];
    end
  end

  // final whitening
  always_ff @(posedge clk) begin
    if (pipe_valid[ROUNDS]) begin
      ciphertext <= pipe_state[ROUNDS] ^ round_key(pipe_key[ROUNDS]);
    end
  end

  `LBCE_ASSERT_IMP(a_done_src, clk, rst, done, $past(accept, ROUNDS + 1),
                   "result without matching request")
  `LBCE_ASSERT_IMP(a_req_done, clk, rst, accept, (##(ROUNDS + 1) done),
                   "request lost in pipeline")
  `LBCE_ASSERT_IMP(a_out_hold, clk, rst, !$stable(ciphertext), done,
                   "ciphertext changed without done")

endmodule
